// ===== hdl/ypcb_pkg.sv =====
package ypcb_pkg;

  localparam int AngleFracBits = 8;
  localparam int VecFracBits   = 14;
  localparam int CordicSteps   = 16;

  localparam int OpW  = 3;
  localparam int IdxW = 5;

  localparam logic [OpW-1:0] OP_NONE = 3'd0;
  localparam logic [OpW-1:0] OP_MUL  = 3'd1;
  localparam logic [OpW-1:0] OP_UPD  = 3'd2;
  localparam logic [OpW-1:0] OP_WRAP = 3'd3;
  localparam logic [OpW-1:0] OP_INIT = 3'd4;
  localparam logic [OpW-1:0] OP_ITER = 3'd5;
  localparam logic [OpW-1:0] OP_SAVE = 3'd6;
  localparam logic [OpW-1:0] OP_PROD = 3'd7;

  // idx selects wrap step, CORDIC step, yaw/pitch (bit 0) or product slot
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [IdxW-1:0] idx;
  } cmd_t;

  localparam logic [15:0] SensReset = 16'd6554;

endpackage

// ===== hdl/yaw_pitch_camera_basis_unit.sv =====
// Yaw/pitch camera basis. Each request carries a pair of mouse deltas; the
// deltas are scaled by the sensitivity register, yaw is wrapped into
// [-180,180) degrees and pitch clamped to +-89 degrees, and the front, right
// and up vectors are produced in Q2.14 together with the new angles. One
// request is worked on at a time: the scaling multiply runs at acceptance,
// then come the angle update, the yaw wrap steps, the shared
// one-step-per-cycle CORDIC (yaw, then pitch), a check that the output
// register is free, and the vector products through the single shared
// multiplier. A result still waiting in the output register holds the
// product phase back. The next request can be taken in the same cycle that
// the result is in the output register, and not before.
module yaw_pitch_camera_basis_unit
  import ypcb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] yaw_deg_o,
  output logic signed [15:0] pitch_deg_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o
);

  logic [15:0] sensitivity_q;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, sensitivity_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensitivity_q <= SensReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      sensitivity_q <= pwdata[15:0];
    end
  end

  ypcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ypcb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sensitivity_i (sensitivity_q),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .yaw_deg_o     (yaw_deg_o),
    .pitch_deg_o   (pitch_deg_o),
    .front_x_o     (front_x_o),
    .front_y_o     (front_y_o),
    .front_z_o     (front_z_o),
    .right_x_o     (right_x_o),
    .right_y_o     (right_y_o),
    .right_z_o     (right_z_o),
    .up_x_o        (up_x_o),
    .up_y_o        (up_y_o),
    .up_z_o        (up_z_o)
  );

endmodule

// ===== hdl/ypcb_ctrl.sv =====
module ypcb_ctrl
  import ypcb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD  = 4'd1;
  localparam logic [3:0] S_WRAP = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_ITER = 4'd4;
  localparam logic [3:0] S_SAVE = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_PROD = 4'd7;

  localparam logic [IdxW-1:0] LastIter = IdxW'(CordicSteps - 1);
  localparam logic [IdxW-1:0] LastProd = IdxW'(4);

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            sel_q, sel_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_MUL;
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.op = OP_UPD;
        cnt_d    = IdxW'(7);
        state_d  = S_WRAP;
      end
      S_WRAP: begin
        cmd_o.op = OP_WRAP;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          sel_d   = 1'b0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.op  = OP_INIT;
        cmd_o.idx = {{(IdxW-1){1'b0}}, sel_q};
        cnt_d     = '0;
        state_d   = S_ITER;
      end
      S_ITER: begin
        cmd_o.op = OP_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastIter) state_d = S_SAVE;
      end
      S_SAVE: begin
        cmd_o.op  = OP_SAVE;
        cmd_o.idx = {{(IdxW-1){1'b0}}, sel_q};
        sel_d     = 1'b1;
        state_d   = sel_q ? S_WAIT : S_INIT;
      end
      S_WAIT: begin
        cnt_d = '0;
        if (!out_valid_q) state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.op = OP_PROD;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastProd) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ypcb_datapath.sv =====
module ypcb_datapath
  import ypcb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [15:0]        sensitivity_i,
  input  logic signed [15:0] delta_x_i,
  input  logic signed [15:0] delta_y_i,
  output logic signed [16:0] yaw_deg_o,
  output logic signed [15:0] pitch_deg_o,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o
);

  localparam int ZShift = 20 - AngleFracBits;
  localparam int DeltaShift = 16 - AngleFracBits;
  localparam logic signed [26:0] HalfTurn = 27'sd180 <<< AngleFracBits;
  localparam logic signed [26:0] FullTurn = 27'sd360 <<< AngleFracBits;
  localparam logic signed [25:0] PitchLim = 26'sd89 <<< AngleFracBits;
  localparam logic signed [31:0] Quarter  = 32'sd90 <<< 20;
  localparam logic signed [33:0] GainQ30  = 34'sd652032874;
  localparam logic signed [15:0] VecLim   = 16'sd1 <<< VecFracBits;
  localparam int ProdShift = 60 - VecFracBits;
  localparam int OneShift  = 30 - VecFracBits;

  localparam logic signed [31:0] AtanTab [24] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
    32'sd1876857, 32'sd938658, 32'sd469357, 32'sd234682, 32'sd117342,
    32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29, 32'sd14, 32'sd7
  };

  function automatic logic signed [15:0] sat_vec(input logic signed [64:0] r);
    logic signed [15:0] res;
    if (r > 65'(VecLim))       res = VecLim;
    else if (r < -65'(VecLim)) res = -VecLim;
    else                       res = r[15:0];
    return res;
  endfunction

  function automatic logic signed [15:0] rnd_prod(input logic signed [64:0] p);
    logic signed [64:0] r;
    r = (p + (65'sd1 <<< (ProdShift - 1))) >>> ProdShift;
    return sat_vec(r);
  endfunction

  function automatic logic signed [15:0] rnd_one(input logic signed [32:0] v);
    logic signed [64:0] r;
    r = (65'(v) + (65'sd1 <<< (OneShift - 1))) >>> OneShift;
    return sat_vec(r);
  endfunction

  logic signed [32:0] px_q, py_q;
  logic signed [26:0] t_q;
  logic signed [16:0] yaw_q;
  logic signed [15:0] pitch_q;
  logic signed [33:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic               neg_q;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
  logic signed [64:0] prod_q;

  logic signed [24:0] dxr, dyr;
  logic signed [26:0] t_sum, t_sub;
  logic signed [25:0] p_sum;
  logic signed [16:0] ang, yaw_new;
  logic signed [31:0] z0;
  logic signed [33:0] xs, ys, cs, ss;
  logic [4:0]         sh;
  logic signed [32:0] ma;
  logic signed [31:0] mb;

  assign dxr   = 25'((px_q + (33'sd1 <<< (DeltaShift - 1))) >>> DeltaShift);
  assign dyr   = 25'((py_q + (33'sd1 <<< (DeltaShift - 1))) >>> DeltaShift);
  assign t_sum = 27'(yaw_q) + 27'(dxr) + HalfTurn;
  assign p_sum = 26'(pitch_q) + 26'(dyr);
  assign t_sub = t_q - (FullTurn <<< cmd_i.idx[2:0]);
  assign yaw_new = 17'(t_q - HalfTurn);
  assign ang   = cmd_i.idx[0] ? 17'(pitch_q) : yaw_new;
  assign z0    = 32'(ang) <<< ZShift;
  assign sh    = cmd_i.idx;
  assign xs    = x_q >>> sh;
  assign ys    = y_q >>> sh;
  assign cs    = neg_q ? -x_q : x_q;
  assign ss    = neg_q ? -y_q : y_q;

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    begin ma = 33'(cy_q);  mb = cp_q; end
      2'd1:    begin ma = 33'(sy_q);  mb = cp_q; end
      2'd2:    begin ma = -33'(cy_q); mb = sp_q; end
      default: begin ma = -33'(sy_q); mb = sp_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= -(17'sd90 <<< AngleFracBits);
      pitch_q <= '0;
    end else begin
      if (cmd_i.op == OP_UPD) begin
        if (p_sum > PitchLim)       pitch_q <= 16'(PitchLim);
        else if (p_sum < -PitchLim) pitch_q <= 16'(-PitchLim);
        else                        pitch_q <= p_sum[15:0];
      end
      if (cmd_i.op == OP_INIT && !cmd_i.idx[0]) yaw_q <= yaw_new;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MUL: begin
        px_q <= 33'(delta_x_i) * $signed({1'b0, sensitivity_i});
        py_q <= 33'(delta_y_i) * $signed({1'b0, sensitivity_i});
      end
      OP_UPD: begin
        // fold negatives up by 128 turns so the wrap only subtracts
        t_q <= t_sum[26] ? t_sum + (FullTurn <<< 7) : t_sum;
      end
      OP_WRAP: begin
        if (!t_sub[26]) t_q <= t_sub;
      end
      OP_INIT: begin
        x_q <= GainQ30;
        y_q <= '0;
        if (z0 > Quarter) begin
          z_q <= z0 - (Quarter <<< 1); neg_q <= 1'b1;
        end else if (z0 < -Quarter) begin
          z_q <= z0 + (Quarter <<< 1); neg_q <= 1'b1;
        end else begin
          z_q <= z0; neg_q <= 1'b0;
        end
      end
      OP_ITER: begin
        if (!z_q[31]) begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - AtanTab[sh];
        end else begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + AtanTab[sh];
        end
      end
      OP_SAVE: begin
        if (cmd_i.idx[0]) begin
          cp_q <= cs[31:0]; sp_q <= ss[31:0];
        end else begin
          cy_q <= cs[31:0]; sy_q <= ss[31:0];
        end
      end
      OP_PROD: begin
        prod_q <= ma * mb;
        // slot n rounds the product taken in slot n-1
        case (cmd_i.idx[2:0])
          3'd1: front_x_o <= rnd_prod(prod_q);
          3'd2: front_z_o <= rnd_prod(prod_q);
          3'd3: up_x_o    <= rnd_prod(prod_q);
          3'd4: begin
            up_z_o      <= rnd_prod(prod_q);
            yaw_deg_o   <= yaw_q;
            pitch_deg_o <= pitch_q;
            front_y_o   <= rnd_one(33'(sp_q));
            right_x_o   <= rnd_one(-33'(sy_q));
            right_y_o   <= '0;
            right_z_o   <= rnd_one(33'(cy_q));
            up_y_o      <= rnd_one(33'(cp_q));
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ypcb_pkg::*;

  localparam int NumFields = 11;
  localparam longint GainQ30 = 64'sd652032874;
  localparam longint AtanDegQ20 [0:15] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
  };

  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } mouse_req_t;

  // yaw, pitch, front xyz, right xyz, up xyz
  typedef struct {
    longint v [NumFields];
  } basis_t;

  string field_name [NumFields] = '{"yaw_deg", "pitch_deg", "front_x", "front_y",
    "front_z", "right_x", "right_y", "right_z", "up_x", "up_y", "up_z"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] delta_x_i = '0, delta_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [16:0] yaw_deg_o;
  logic signed [15:0] pitch_deg_o, front_x_o, front_y_o, front_z_o;
  logic signed [15:0] right_x_o, right_y_o, right_z_o, up_x_o, up_y_o, up_z_o;

  mouse_req_t req_q [$];
  basis_t basis_q [$];
  mouse_req_t next_req;
  basis_t seen;

  logic [15:0] sens_model = SensReset;
  longint yaw_model = -(64'sd90 <<< AngleFracBits);
  longint pitch_model = 0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int n_req = 0, n_res = 0, n_err = 0, n_cfg = 0;

  always #6 clk_i = ~clk_i;

  yaw_pitch_camera_basis_unit uut (.*);

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint vec_sat(longint v, int s);
    longint r;
    longint lim;
    r = rnd_shift(v, s);
    lim = 64'sd1 <<< VecFracBits;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // rotation-mode CORDIC, angle in degrees Q.8, cos/sin in Q.30
  task automatic cordic_deg(input longint ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    longint quarter;
    bit flip;
    z = ang <<< (20 - AngleFracBits);
    quarter = 64'sd90 <<< 20;
    x = GainQ30;
    y = 0;
    flip = 1'b0;
    if (z > quarter) begin
      z -= 2 * quarter;
      flip = 1'b1;
    end else if (z < -quarter) begin
      z += 2 * quarter;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanDegQ20[i];
      end else begin
        x += dx; y -= dy; z += AtanDegQ20[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic advance_camera(input mouse_req_t r, output basis_t b);
    longint d_yaw, d_pitch, half, full, lim, t, cy, sy, cp, sp;
    int s1, s2;
    s1 = 30 - VecFracBits;
    s2 = 60 - VecFracBits;
    d_yaw = rnd_shift(longint'(r.dx) * longint'(sens_model), 16 - AngleFracBits);
    d_pitch = rnd_shift(longint'(r.dy) * longint'(sens_model), 16 - AngleFracBits);
    half = 64'sd180 <<< AngleFracBits;
    full = 2 * half;
    lim = 64'sd89 <<< AngleFracBits;
    t = (yaw_model + d_yaw + half) % full;
    if (t < 0) t += full;
    yaw_model = t - half;
    t = pitch_model + d_pitch;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    pitch_model = t;
    cordic_deg(yaw_model, cy, sy);
    cordic_deg(pitch_model, cp, sp);
    b.v[0] = yaw_model;
    b.v[1] = pitch_model;
    b.v[2] = vec_sat(cy * cp, s2);
    b.v[3] = vec_sat(sp, s1);
    b.v[4] = vec_sat(sy * cp, s2);
    b.v[5] = vec_sat(-sy, s1);
    b.v[6] = 0;
    b.v[7] = vec_sat(cy, s1);
    b.v[8] = vec_sat(-(cy * sp), s2);
    b.v[9] = vec_sat(cp, s1);
    b.v[10] = vec_sat(-(sy * sp), s2);
  endtask

  // request side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        basis_t b;
        advance_camera('{dx: delta_x_i, dy: delta_y_i}, b);
        basis_q.push_back(b);
        n_req++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
          next_req = req_q.pop_front();
          in_valid_i <= 1'b1;
          delta_x_i <= next_req.dx;
          delta_y_i <= next_req.dy;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 600;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.v = '{yaw_deg_o, pitch_deg_o, front_x_o, front_y_o, front_z_o, right_x_o,
        right_y_o, right_z_o, up_x_o, up_y_o, up_z_o};
      n_res++;
      if (basis_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: result with nothing outstanding at %0t", $time);
      end else begin
        basis_t e;
        e = basis_q.pop_front();
        for (int i = 0; i < NumFields; i++) begin
          if (seen.v[i] != e.v[i]) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: result %0d %s expected %0d got %0d", n_res, field_name[i],
                e.v[i], seen.v[i]);
          end
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) sens_model = data[15:0];
    n_cfg++;
  endtask

  task automatic drain;
    while (req_q.size() > 0 || in_valid_i || basis_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_req(input int dx, input int dy);
    req_q.push_back('{dx: 16'(dx), dy: 16'(dy)});
  endtask

  task automatic random_walk(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85)
        push_req($urandom_range(4000) - 2000, $urandom_range(4000) - 2000);
      else
        push_req($urandom_range(65535), $urandom_range(65535));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sensitivity, field extremes
    push_req(0, 0);
    push_req(32767, 32767);
    push_req(-32768, -32768);
    push_req(16'h5555, 16'haaaa);
    push_req(-1, 1);
    drain();

    // unit scale: exact quarter turns, the yaw wrap and the pitch clamp
    apb_write(3'd0, 32'hdead_0100);
    push_req(23040, 22784);
    push_req(23040, 1);
    push_req(23040, -22784);
    push_req(23040, -22784);
    push_req(-1, -1);
    push_req(1, 45568);
    push_req(-23040, 0);
    drain();

    // out-of-range register index must leave sensitivity alone
    apb_write(3'd4, 32'h0000_0000);
    push_req(256, 256);
    push_req(-512, 100);
    drain();

    apb_write(3'd0, 32'h0000_ffff);
    push_req(32767, 1);
    push_req(-32768, -1);
    push_req(12345, -12345);
    random_walk(180);
    drain();

    apb_write(3'd0, 32'h0000_0000);
    push_req(32767, -32768);
    random_walk(60);
    drain();

    // receiver holds off while requests keep coming
    apb_write(3'd0, 32'hffff_0000 | 32'(SensReset));
    random_walk(40);
    hold_req <= 1'b1;
    random_walk(160);
    drain();

    // no idling on either side
    calm = 1'b1;
    apb_write(3'd0, 32'($urandom_range(65535)));
    random_walk(200);
    drain();
    calm = 1'b0;

    apb_write(3'd0, 32'($urandom_range(2000)));
    random_walk(250);
    drain();

    apb_write(3'd0, 32'($urandom));
    random_walk(240);
    drain();

    repeat (60) @(posedge clk_i);
    $display("Covered %0d requests and %0d results over %0d register writes,",
      n_req, n_res, n_cfg);
    $display("including the wrap, the pitch clamp, zero and full sensitivity.");
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_err);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout: %0d results outstanding", basis_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
